[design/fed_pkg.sv]
package fed_pkg;

  // Default line length and field widths
  localparam int DEPTH_DEF = 4096;
  localparam int SAMPLE_W  = 16;
  localparam int OUT_W     = 17;
  localparam int DELAY_W   = 12;
  localparam int GAIN_W    = 17;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
  localparam int SUM_W     = PROD_W + 1;

  localparam logic [GAIN_W-1:0]  GAIN_ONE  = 17'h10000;
  localparam logic [DELAY_W-1:0] DELAY_RST = 12'd4095;
  localparam logic [GAIN_W-1:0]  FB_RST    = 17'd0;
  localparam logic [GAIN_W-1:0]  MIX_RST   = 17'd32768;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DELAY    = 2'd0,
    REG_FEEDBACK = 2'd1,
    REG_MIX      = 2'd2
  } cfg_reg_t;

  // Pipeline status seen by the address stage
  typedef struct packed {
    logic s1_free;
    logic hazard;
  } pipe_stat_t;

  // Q16 weighted sum scaled back, truncated toward zero
  function automatic logic signed [SAMPLE_W-1:0] q16_trunc(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] q;
    q = s >>> FRAC_W;
    if (s[SUM_W-1] && (|s[FRAC_W-1:0])) begin
      q = q + SUM_W'(1);
    end
    return q[SAMPLE_W-1:0];
  endfunction

endpackage

[design/feedback_echo_delay.sv]
// Feedback echo with dry/wet mix.
// Input channel: in_valid/in_ready carry one signed 16-bit sample_in per item.
// Output channel: out_valid/out_ready carry sample_out, twice the mixed
// sample, exactly one per input item and in input order.
// Config port: cfg_we writes cfg_data into register cfg_index (0 delay_time,
// 1 feedback_gain, 2 mix_level) in the same cycle; write only while idle.
// An accepted item moves through stage 1, stage 2 and the output register.
// Throughput: one item per cycle while the receiver takes results and the
// saturated delay is 0 or 3 or more, or on the first pass. With a delay of
// 1 or 2 an item waits until the write of its tap entry by an earlier item
// has reached the delay RAM and the rate falls below that, a limit set by
// the read-multiply-write loop through the RAM.
// Reset (synchronous, rst) clears the pipeline, the write pointer and the
// first-pass flag and loads the register defaults; the RAM needs no clear.
// When the receiver stalls, the result is held in the output register and
// the pipeline keeps taking items until its three stages are full.
module feedback_echo_delay import fed_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_W-1:0]    sample_out,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [GAIN_W-1:0]          cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = (AW > DELAY_W) ? AW : DELAY_W;

  logic [DELAY_W-1:0] delay_time;
  logic [GAIN_W-1:0]  feedback_gain;
  logic [GAIN_W-1:0]  mix_level;

  logic [CW-1:0]       delay_ext;
  logic [CW-1:0]       delay_sat;
  logic [GAIN_W-1:0]   fb_sat;
  logic [GAIN_W-1:0]   lv_sat;

  pipe_stat_t          stat;
  logic                fire;
  logic [AW-1:0]       wr_ptr;
  logic                filled;
  logic [AW-1:0]       tap_addr;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [SAMPLE_W-1:0] wdata;
  logic [SAMPLE_W-1:0] rd_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_time    <= DELAY_RST;
      feedback_gain <= FB_RST;
      mix_level     <= MIX_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DELAY:    delay_time    <= cfg_data[DELAY_W-1:0];
        REG_FEEDBACK: feedback_gain <= cfg_data;
        REG_MIX:      mix_level     <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Saturate gains to one and delay to DEPTH-1
  assign fb_sat    = (feedback_gain > GAIN_ONE) ? GAIN_ONE : feedback_gain;
  assign lv_sat    = (mix_level > GAIN_ONE) ? GAIN_ONE : mix_level;
  assign delay_ext = CW'(delay_time);
  assign delay_sat = (delay_ext > CW'(DEPTH - 1)) ? CW'(DEPTH - 1) : delay_ext;

  fed_addr #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_addr (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .delay_sat (delay_sat),
    .stat      (stat),
    .in_ready  (in_ready),
    .fire      (fire),
    .wr_ptr    (wr_ptr),
    .filled    (filled),
    .tap_addr  (tap_addr)
  );

  fed_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (fire),
    .raddr (tap_addr),
    .rdata (rd_data)
  );

  fed_mix #(
    .AW (AW)
  ) u_mix (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .sample_in  (sample_in),
    .wr_ptr     (wr_ptr),
    .filled     (filled),
    .tap_addr   (tap_addr),
    .rd_data    (rd_data),
    .fb_gain    (fb_sat),
    .mix_gain   (lv_sat),
    .out_ready  (out_ready),
    .stat       (stat),
    .out_valid  (out_valid),
    .sample_out (sample_out),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata)
  );

endmodule

[design/fed_ram.sv]
module fed_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/fed_addr.sv]
module fed_addr import fed_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = 12,
  parameter int CW    = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [CW-1:0] delay_sat,
  input  pipe_stat_t    stat,
  output logic          in_ready,
  output logic          fire,
  output logic [AW-1:0] wr_ptr,
  output logic          filled,
  output logic [AW-1:0] tap_addr
);

  localparam int XW = CW + 2;

  logic [XW-1:0] ptr_x;
  logic [XW-1:0] dt_x;
  logic [XW-1:0] tap_x;

  // Tap sits delay_sat entries behind the write pointer, modulo DEPTH
  always_comb begin
    ptr_x = XW'(wr_ptr);
    dt_x  = XW'(delay_sat);
    if (ptr_x >= dt_x) begin
      tap_x = ptr_x - dt_x;
    end else begin
      tap_x = ptr_x + XW'(DEPTH) - dt_x;
    end
    tap_addr = tap_x[AW-1:0];
  end

  // Hold the item while stage 1 cannot take it or, once the line is filled, its tap entry still has a write in flight
  assign in_ready = stat.s1_free && !(filled && stat.hazard);
  assign fire     = in_valid && in_ready;

  // Write pointer and first-pass flag
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      filled <= 1'b0;
    end else if (fire) begin
      if (wr_ptr == AW'(DEPTH - 1)) begin
        wr_ptr <= '0;
        filled <= 1'b1;
      end else begin
        wr_ptr <= wr_ptr + AW'(1);
      end
    end
  end

endmodule

[design/fed_mix.sv]
module fed_mix import fed_pkg::*; #(
  parameter int AW = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic [AW-1:0]              wr_ptr,
  input  logic                       filled,
  input  logic [AW-1:0]              tap_addr,
  input  logic [SAMPLE_W-1:0]        rd_data,
  input  logic [GAIN_W-1:0]          fb_gain,
  input  logic [GAIN_W-1:0]          mix_gain,
  input  logic                       out_ready,
  output pipe_stat_t                 stat,
  output logic                       out_valid,
  output logic signed [OUT_W-1:0]    sample_out,
  output logic                       we,
  output logic [AW-1:0]              waddr,
  output logic [SAMPLE_W-1:0]        wdata
);

  // Stage 1: sample, pointer, tap arrives from the RAM
  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_x;
  logic [AW-1:0]              s1_ptr;
  logic                       s1_filled;

  // Stage 2: registered products
  logic                     s2_valid;
  logic [AW-1:0]            s2_ptr;
  logic signed [PROD_W-1:0] p_x_fb;
  logic signed [PROD_W-1:0] p_t_fb;
  logic signed [PROD_W-1:0] p_x_lv;
  logic signed [PROD_W-1:0] p_t_lv;

  logic s3_free;
  logic s2_free;
  logic s2_adv;
  logic s1_adv;

  logic signed [SAMPLE_W-1:0] tap;
  logic signed [GAIN_W:0]     g_fb;
  logic signed [GAIN_W:0]     g_fb_c;
  logic signed [GAIN_W:0]     g_lv;
  logic signed [GAIN_W:0]     g_lv_c;
  logic signed [SUM_W-1:0]    sum_fb;
  logic signed [SUM_W-1:0]    sum_lv;
  logic signed [SAMPLE_W-1:0] stored;
  logic signed [SAMPLE_W-1:0] mixed;

  // Stage flow control
  assign s3_free = !out_valid || out_ready;
  assign s2_free = !s2_valid || s3_free;
  assign s2_adv  = s2_valid && s3_free;
  assign s1_adv  = s1_valid && s2_free;

  assign stat.s1_free = !s1_valid || s2_free;
  assign stat.hazard  = (s1_valid && (s1_ptr == tap_addr)) ||
                        (s2_valid && (s2_ptr == tap_addr));

  // Gains and their complements as signed operands
  assign g_fb   = signed'({1'b0, fb_gain});
  assign g_fb_c = signed'({1'b0, GAIN_ONE - fb_gain});
  assign g_lv   = signed'({1'b0, mix_gain});
  assign g_lv_c = signed'({1'b0, GAIN_ONE - mix_gain});

  // No echo on the first pass
  assign tap = s1_filled ? signed'(rd_data) : '0;

  // Weighted sums and truncation
  always_comb begin
    sum_fb = SUM_W'(p_x_fb) + SUM_W'(p_t_fb);
    sum_lv = SUM_W'(p_x_lv) + SUM_W'(p_t_lv);
    stored = q16_trunc(sum_fb);
    mixed  = q16_trunc(sum_lv);
  end

  // Write-back of the new line entry
  assign we    = s2_adv;
  assign waddr = s2_ptr;
  assign wdata = stored;

  // Control of the three stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (fire) begin
      s1_x      <= sample_in;
      s1_ptr    <= wr_ptr;
      s1_filled <= filled;
    end
    if (s1_adv) begin
      s2_ptr <= s1_ptr;
      p_x_fb <= PROD_W'(s1_x * g_fb_c);
      p_t_fb <= PROD_W'(tap * g_fb);
      p_x_lv <= PROD_W'(s1_x * g_lv_c);
      p_t_lv <= PROD_W'(tap * g_lv);
    end
    if (s2_adv) begin
      sample_out <= {mixed, 1'b0};
    end
  end

endmodule

[design/fed_checker.sv]
module fed_checker import fed_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic signed [SAMPLE_W-1:0] sample_in,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [OUT_W-1:0]    sample_out
);

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("stalled result changed");

  // A waiting input item stays put
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(sample_in))
    else $error("waiting item changed");

  // A result appearing on an empty output follows an accepted item through stage 1 and stage 2
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 3))
    else $error("result without matching item");

  // Empty block with no history is ready at once after reset
  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_ready)
    else $error("not ready after reset");

endmodule

bind feedback_echo_delay fed_checker u_fed_checker (.*);

[bench/feedback_echo_delay_checker.sv]
`timescale 1ns / 1ps
module feedback_echo_delay_checker
  import fed_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [OUT_W-1:0]    sample_out,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [GAIN_W-1:0]          cfg_data,
  output int                         errors,
  output int                         waiting
);

  // Shadow copy of the delay line, pointer, first-pass flag and registers
  logic signed [SAMPLE_W-1:0] echo_line [DEPTH_DEF];
  logic [DELAY_W-1:0]         wr_ptr;
  logic                       line_full;
  logic [DELAY_W-1:0]         delay_reg;
  logic [GAIN_W-1:0]          fb_reg;
  logic [GAIN_W-1:0]          mix_reg;
  logic signed [OUT_W-1:0]    expected_out [$];

  // dry*(1-g) + wet*g in Q16, truncated toward zero; gains above one clamp
  function automatic longint blend_q16(input longint dry, input longint wet,
                                       input logic [GAIN_W-1:0] gain);
    longint g;
    g = (gain > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(gain);
    return (dry * (longint'(GAIN_ONE) - g) + wet * g) / longint'(GAIN_ONE);
  endfunction

  initial begin
    errors  = 0;
    waiting = 0;
  end

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] tap;
    logic signed [OUT_W-1:0]    got;
    logic signed [OUT_W-1:0]    want;
    longint                     stored;
    longint                     mixed;

    if (rst) begin
      wr_ptr    = '0;
      line_full = 1'b0;
      delay_reg = DELAY_RST;
      fb_reg    = FB_RST;
      mix_reg   = MIX_RST;
      expected_out.delete();
      waiting <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_DELAY:    delay_reg = cfg_data[DELAY_W-1:0];
          REG_FEEDBACK: fb_reg = cfg_data;
          REG_MIX:      mix_reg = cfg_data;
          default: ;
        endcase
      end

      // accepted sample: read tap before the write, a zero delay is a full lap
      if (in_valid && in_ready) begin
        tap    = line_full ? echo_line[DELAY_W'(wr_ptr - delay_reg)] : '0;
        stored = blend_q16(sample_in, tap, fb_reg);
        mixed  = blend_q16(sample_in, tap, mix_reg);
        echo_line[wr_ptr] = SAMPLE_W'(stored);
        wr_ptr = wr_ptr + 1'b1;
        if (wr_ptr == '0) begin
          line_full = 1'b1;
        end
        expected_out.push_back(OUT_W'(mixed * 2));
      end

      // accepted result against the oldest expectation
      if (out_valid && out_ready) begin
        got = sample_out;
        if (expected_out.size() == 0) begin
          errors++;
          $display("%0t: sample_out %0d arrived, expected none", $time, got);
        end else begin
          want = expected_out.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, want, got);
          end
        end
      end

      waiting <= expected_out.size();
    end
  end

endmodule

[bench/feedback_echo_delay_tb.sv]
`timescale 1ns / 1ps
module feedback_echo_delay_tb;
  import fed_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int TAIL_CYCLES   = 10;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [OUT_W-1:0]    sample_out;
  logic                       cfg_we;
  logic [1:0]                 cfg_index;
  logic [GAIN_W-1:0]          cfg_data;

  int src_idle   = 0;
  int sink_stall = 0;
  int sent       = 0;
  int cycles     = 0;
  int errors;
  int waiting;

  feedback_echo_delay uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  feedback_echo_delay_checker echo_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .waiting    (waiting)
  );

  always #4 clk = ~clk;

  // receiver back-pressure
  initial out_ready = 1'b0;
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // mostly full-range samples, with the two rails now and then
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // full 17-bit data so the bits above the delay field toggle too
  function automatic logic [GAIN_W-1:0] pick_delay();
    case ($urandom_range(5))
      0:       return '0;
      1:       return GAIN_W'(1);
      2:       return GAIN_W'(2);
      3:       return GAIN_W'(DEPTH_DEF - 1);
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return GAIN_ONE;
      2:       return GAIN_W'($urandom_range(2**GAIN_W - 1, 65537));
      default: return GAIN_W'($urandom_range(65536));
    endcase
  endfunction

  // idle mix per phase: none, sender, receiver, both
  task automatic set_mode(input int m);
    case (m % 4)
      0: begin src_idle = 0;  sink_stall = 0;  end
      1: begin src_idle = 68; sink_stall = 0;  end
      2: begin src_idle = 0;  sink_stall = 68; end
      default: begin src_idle = 22; sink_stall = 22; end
    endcase
  endtask

  // one item on the input channel; valid stays up until accepted
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic run_burst(input int n);
    repeat (n) send_sample(rand_sample());
  endtask

  // wait for every result, then let the pipeline go quiet
  task automatic drain_line();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all three registers on back-to-back cycles
  task automatic write_regs(input logic [GAIN_W-1:0] dly, input logic [GAIN_W-1:0] fb,
                            input logic [GAIN_W-1:0] mix);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DELAY;
    cfg_data  <= dly;
    @(posedge clk);
    cfg_index <= REG_FEEDBACK;
    cfg_data  <= fb;
    @(posedge clk);
    cfg_index <= REG_MIX;
    cfg_data  <= mix;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int phase;

    in_valid  = 1'b0;
    sample_in = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_DELAY;
    cfg_data  = '0;
    phase     = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // first pass, reset register values
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shFFFF);
    send_sample(16'sh0001);
    send_sample(16'sh5555);
    drain_line();

    // first pass: dry only, then gains above one (dry muted, nothing stored)
    write_regs('0, GAIN_ONE, '0);
    send_sample(16'sh8000);
    send_sample(16'shAAAA);
    drain_line();
    write_regs(GAIN_W'(DEPTH_DEF - 1), '1, '1);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);

    // finish the first lap of the line with random settings
    while (sent < DEPTH_DEF) begin
      drain_line();
      write_regs(pick_delay(), pick_gain(), pick_gain());
      set_mode(phase);
      run_burst((DEPTH_DEF - sent < 400) ? DEPTH_DEF - sent : 400);
      phase++;
    end
    set_mode(0);

    // zero delay is a full lap; fully wet with full feedback
    drain_line();
    write_regs('0, GAIN_ONE, GAIN_ONE);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0001);
    send_sample(16'shFFFF);

    // shortest delays, where the tap was written just before
    drain_line();
    write_regs(GAIN_W'(1), GAIN_W'(40000), GAIN_W'(20000));
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    drain_line();
    write_regs(GAIN_W'(2), '1, '0);
    send_sample(16'sh4000);
    send_sample(16'shC000);
    send_sample(16'sh1234);

    // delay data with the upper bits set
    drain_line();
    write_regs(GAIN_W'('h1F003), GAIN_W'(12345), GAIN_W'(65535));
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0000);

    // random phases over the filled line
    for (int p = 0; p < 12; p++) begin
      drain_line();
      write_regs(pick_delay(), pick_gain(), pick_gain());
      set_mode(p);
      run_burst(50);
    end

    // wait out the pipeline and give the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/fed_pkg.sv
design/fed_ram.sv
design/fed_addr.sv
design/fed_mix.sv
design/feedback_echo_delay.sv
design/fed_checker.sv
bench/feedback_echo_delay_checker.sv
bench/feedback_echo_delay_tb.sv
